// ----- rtl/dcmas_pkg.sv -----
// ----------------------------------------------------------------------------
// dcmas_pkg
// constants and widths shared by the dual channel moving average scaler
// ----------------------------------------------------------------------------
package dcmas_pkg;

   localparam int WINDOW_DEPTH = 64;

   localparam int SAMPLE_W = 10;
   localparam int POS_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W    = SAMPLE_W + POS_W;
   localparam int ADDR_W   = POS_W + 1;
   localparam int CNT_W    = $clog2(SUM_W);

   localparam int GAIN_W   = 16;
   localparam int SUPPLY_W = 13;
   localparam int OFFSET_W = 12;
   localparam int MUX_W    = 10;
   localparam int CSR_W    = 16;
   localparam int INDEX_W  = 2;

   localparam int AVG_W    = SAMPLE_W + 1;
   localparam int MUL_W    = 18;
   localparam int PROD_W   = 28;
   localparam int BASE_W   = 12;
   localparam int VALUE_W  = 20;

   // floor(x / 5) == (x * RECIP_FIVE) >> RECIP_SHIFT for x below 2**15
   localparam int RECIP_FIVE  = 52429;
   localparam int RECIP_SHIFT = 18;
   localparam int TURB_SHIFT  = 8;
   localparam int ORP_SHIFT   = 10;

   localparam logic [INDEX_W-1:0] REG_TURB_GAIN  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_SUPPLY_MV  = 2'd1;
   localparam logic [INDEX_W-1:0] REG_ORP_OFFSET = 2'd2;
   localparam logic [INDEX_W-1:0] REG_MUX_OFFSET = 2'd3;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd256;
   localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 13'd3300;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;
   localparam logic CH_TURB    = 1'b0;
   localparam logic CH_ORP     = 1'b1;

   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [FILL_W-1:0] fill_type;

endpackage

// ----- rtl/dual_channel_moving_average_scaler.sv -----
// ----------------------------------------------------------------------------
// dual_channel_moving_average_scaler
// Each transfer is a new sample for one of two channels or a clear of both.
// A sample enters its channel's 64-entry window (one shared block RAM, one
// half per channel); the window sum is divided by the fill count with a
// restoring divider that retires one quotient bit per cycle, the average
// less the mux offset is scaled by one shared 18x18 multiplier (twice for
// ORP: once for the average term, once for the supply*2/5 term by
// reciprocal), and one result is returned. A sample passes through the load,
// divide, scale, base (ORP only) and done states, and its result enters the
// output register from the done state once any unaccepted earlier result
// has left it; a clear is taken from idle and returns no result. No new
// transfer is taken until the current one is finished and its result is in
// the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module dual_channel_moving_average_scaler
   import dcmas_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_action,
   input  logic                       req_channel,
   input  logic [SAMPLE_W-1:0]        req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_out_channel,
   output logic signed [VALUE_W-1:0]  rsp_value,
   input  logic                       csr_write,
   input  logic [INDEX_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_BASE  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   logic [GAIN_W-1:0]          gain_ff;
   logic [SUPPLY_W-1:0]        supply_ff;
   logic signed [OFFSET_W-1:0] orp_offset_ff;
   logic [MUX_W-1:0]           mux_offset_ff;

   sum_type  turb_sum_ff, turb_sum_in, orp_sum_ff, orp_sum_in;
   pos_type  turb_pos_ff, turb_pos_in, orp_pos_ff, orp_pos_in;
   fill_type turb_fill_ff, turb_fill_in, orp_fill_ff, orp_fill_in;

   logic                chan_ff, chan_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   sum_type             div_quo_ff, div_quo_in;
   logic [FILL_W-1:0]   div_rem_ff, div_rem_in;
   fill_type            div_den_ff, div_den_in;
   logic [CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [BASE_W-1:0]        base_ff, base_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_chan_ff, out_chan_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;

   logic [SAMPLE_W-1:0] ring_mem [2**ADDR_W];
   logic [SAMPLE_W-1:0] mem_rd_ff;
   logic [ADDR_W-1:0]   mem_raddr, mem_waddr;
   logic                mem_we;

   sum_type             sel_sum, new_sum;
   pos_type             sel_pos, new_pos;
   fill_type            sel_fill, new_fill;
   logic [SAMPLE_W-1:0] old_sample;
   logic [FILL_W:0]     div_trial;
   logic                div_bit;

   logic signed [AVG_W-1:0]    avg;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [2*MUL_W-1:0]  mul_p;
   logic signed [PROD_W-1:0]   turb_shift, turb_round, orp_shift;
   logic signed [VALUE_W-1:0]  turb_value, orp_value;

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = out_chan_ff;
   assign rsp_value       = value_ff;

   assign mem_raddr = {req_channel, (req_channel == CH_ORP) ? orp_pos_ff : turb_pos_ff};
   assign mem_waddr = {chan_ff, sel_pos};

   assign sel_sum    = (chan_ff == CH_ORP) ? orp_sum_ff  : turb_sum_ff;
   assign sel_pos    = (chan_ff == CH_ORP) ? orp_pos_ff  : turb_pos_ff;
   assign sel_fill   = (chan_ff == CH_ORP) ? orp_fill_ff : turb_fill_ff;
   // entries past the fill count were never written since the last clear
   assign old_sample = (sel_fill == FILL_W'(WINDOW_DEPTH)) ? mem_rd_ff : '0;
   assign new_sum    = sel_sum - SUM_W'(old_sample) + SUM_W'(sample_ff);
   assign new_pos    = (sel_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : sel_pos + 1'b1;
   assign new_fill   = (sel_fill == FILL_W'(WINDOW_DEPTH)) ? sel_fill : sel_fill + 1'b1;

   assign div_trial = {div_rem_ff, div_quo_ff[SUM_W-1]};
   assign div_bit   = (div_trial >= {1'b0, div_den_ff});

   assign avg   = $signed({1'b0, div_quo_ff[SAMPLE_W-1:0]} - {1'b0, mux_offset_ff});
   assign mul_p = mul_a * mul_b;

   // turbidity divides by 256 toward zero, orp by 1024 toward minus infinity
   assign turb_shift = prod_ff >>> TURB_SHIFT;
   assign turb_round = turb_shift + PROD_W'(prod_ff[PROD_W-1] && (|prod_ff[TURB_SHIFT-1:0]));
   assign turb_value = turb_round[VALUE_W-1:0];
   assign orp_shift  = prod_ff >>> ORP_SHIFT;
   assign orp_value  = $signed(VALUE_W'(base_ff)) - orp_shift[VALUE_W-1:0]
                     + VALUE_W'(orp_offset_ff);

   always_comb begin
      state_in     = state_ff;
      turb_sum_in  = turb_sum_ff;
      turb_pos_in  = turb_pos_ff;
      turb_fill_in = turb_fill_ff;
      orp_sum_in   = orp_sum_ff;
      orp_pos_in   = orp_pos_ff;
      orp_fill_in  = orp_fill_ff;
      chan_in      = chan_ff;
      sample_in    = sample_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff;
      out_chan_in  = out_chan_ff;
      value_in     = value_ff;
      mem_we       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_CLEAR) begin
                  turb_sum_in  = '0;
                  turb_pos_in  = '0;
                  turb_fill_in = '0;
                  orp_sum_in   = '0;
                  orp_pos_in   = '0;
                  orp_fill_in  = '0;
               end else begin
                  chan_in   = req_channel;
                  sample_in = req_sample;
                  state_in  = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            mem_we = 1'b1;
            if (chan_ff == CH_ORP) begin
               orp_sum_in  = new_sum;
               orp_pos_in  = new_pos;
               orp_fill_in = new_fill;
            end else begin
               turb_sum_in  = new_sum;
               turb_pos_in  = new_pos;
               turb_fill_in = new_fill;
            end
            div_quo_in = new_sum;
            div_rem_in = '0;
            div_den_in = new_fill;
            div_cnt_in = CNT_W'(SUM_W - 1);
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (div_bit) begin
               div_rem_in = FILL_W'(div_trial - {1'b0, div_den_ff});
            end else begin
               div_rem_in = div_trial[FILL_W-1:0];
            end
            div_quo_in = {div_quo_ff[SUM_W-2:0], div_bit};
            if (div_cnt_ff == '0) begin
               state_in = S_SCALE;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         S_SCALE: begin
            mul_a = MUL_W'(avg);
            if (chan_ff == CH_ORP) begin
               mul_b    = $signed(MUL_W'(supply_ff));
               state_in = S_BASE;
            end else begin
               mul_b    = $signed(MUL_W'(gain_ff));
               state_in = S_DONE;
            end
            prod_in = mul_p[PROD_W-1:0];
         end
         S_BASE: begin
            mul_a    = $signed(MUL_W'({supply_ff, 1'b0}));
            mul_b    = $signed(MUL_W'(RECIP_FIVE));
            base_in  = mul_p[RECIP_SHIFT +: BASE_W];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_chan_in  = chan_ff;
               value_in     = (chan_ff == CH_ORP) ? orp_value : turb_value;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= sample_ff;
      end
      mem_rd_ff <= ring_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         turb_sum_ff   <= '0;
         turb_pos_ff   <= '0;
         turb_fill_ff  <= '0;
         orp_sum_ff    <= '0;
         orp_pos_ff    <= '0;
         orp_fill_ff   <= '0;
         gain_ff       <= GAIN_RESET;
         supply_ff     <= SUPPLY_RESET;
         orp_offset_ff <= '0;
         mux_offset_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         turb_sum_ff  <= turb_sum_in;
         turb_pos_ff  <= turb_pos_in;
         turb_fill_ff <= turb_fill_in;
         orp_sum_ff   <= orp_sum_in;
         orp_pos_ff   <= orp_pos_in;
         orp_fill_ff  <= orp_fill_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_TURB_GAIN:  gain_ff       <= csr_wdata[GAIN_W-1:0];
               REG_SUPPLY_MV:  supply_ff     <= csr_wdata[SUPPLY_W-1:0];
               REG_ORP_OFFSET: orp_offset_ff <= $signed(csr_wdata[OFFSET_W-1:0]);
               REG_MUX_OFFSET: mux_offset_ff <= csr_wdata[MUX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      sample_ff   <= sample_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_cnt_ff  <= div_cnt_in;
      prod_ff     <= prod_in;
      base_ff     <= base_in;
      out_chan_ff <= out_chan_in;
      value_ff    <= value_in;
   end

endmodule

// ----- tb/dual_channel_moving_average_scaler_test.sv -----
// ----------------------------------------------------------------------------
// dual_channel_moving_average_scaler_test
// Drives sample and clear transfers into the two-channel moving average
// scaler under random valid gaps and result stalls. A scoreboard keeps its
// own copy of both sample windows and of the register settings, predicts
// the scaled average for every accepted sample, and checks each result
// transfer in order. Register settings change between phases, with the
// block drained first, and include the extremes of every register.
// ----------------------------------------------------------------------------
module dual_channel_moving_average_scaler_test
   import dcmas_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 118;
   localparam int PHASE_COUNT   = 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic               channel;
      logic [VALUE_W-1:0] value;
   } scaled_result_type;

   class scaled_average_board;
      logic [SAMPLE_W-1:0] window [2][WINDOW_DEPTH];
      sum_type             total [2];
      pos_type             head [2];
      fill_type            fill [2];
      logic [GAIN_W-1:0]   turb_gain;
      logic [SUPPLY_W-1:0] supply_mv;
      logic signed [OFFSET_W-1:0] orp_offset;
      logic [MUX_W-1:0]    mux_offset;
      scaled_result_type   pending [$];
      int                  mismatches;

      function new();
         clear_windows();
         turb_gain  = GAIN_RESET;
         supply_mv  = SUPPLY_RESET;
         orp_offset = '0;
         mux_offset = '0;
         mismatches = 0;
      endfunction

      function void clear_windows();
         for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) window[c][i] = '0;
            total[c] = '0;
            head[c]  = '0;
            fill[c]  = '0;
         end
      endfunction

      function void set_register(logic [INDEX_W-1:0] index, logic [CSR_W-1:0] data);
         case (index)
            REG_TURB_GAIN:  turb_gain  = data[GAIN_W-1:0];
            REG_SUPPLY_MV:  supply_mv  = data[SUPPLY_W-1:0];
            REG_ORP_OFFSET: orp_offset = data[OFFSET_W-1:0];
            REG_MUX_OFFSET: mux_offset = data[MUX_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_transfer(logic action, logic channel, logic [SAMPLE_W-1:0] sample);
         int                c;
         longint            average;
         longint            scaled;
         scaled_result_type exp_result;
         if (action == ACT_CLEAR) begin
            clear_windows();
            return;
         end
         c = (channel == CH_ORP) ? 1 : 0;
         if (fill[c] < WINDOW_DEPTH) fill[c] = fill[c] + 1'b1;
         total[c] = total[c] - window[c][head[c]] + sample;
         window[c][head[c]] = sample;
         head[c] = (head[c] == WINDOW_DEPTH - 1) ? '0 : head[c] + 1'b1;
         average = longint'(total[c] / fill[c]) - longint'(mux_offset);
         if (channel == CH_TURB) begin
            scaled = (average * longint'(turb_gain)) / 256;
         end else begin
            scaled = (longint'(supply_mv) * 2) / 5
                   - ((average * longint'(supply_mv)) >>> ORP_SHIFT)
                   + longint'(orp_offset);
         end
         exp_result.channel = channel;
         exp_result.value   = scaled[VALUE_W-1:0];
         pending.push_back(exp_result);
      endfunction

      function void check_result(logic channel, logic [VALUE_W-1:0] value);
         scaled_result_type exp_result;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result channel %0d value %0d",
                        $realtime, channel, $signed(value));
            return;
         end
         exp_result = pending.pop_front();
         if (channel !== exp_result.channel || value !== exp_result.value) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result mismatch, expected channel %0d value %0d,",
                        $realtime, exp_result.channel, $signed(exp_result.value),
                        " got channel %0d value %0d", channel, $signed(value));
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_action = ACT_SAMPLE;
   logic                      req_channel = CH_TURB;
   logic [SAMPLE_W-1:0]       req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_out_channel;
   logic signed [VALUE_W-1:0] rsp_value;
   logic                      csr_write = 1'b0;
   logic [INDEX_W-1:0]        csr_index = REG_TURB_GAIN;
   logic [CSR_W-1:0]          csr_wdata = '0;

   scaled_average_board board;
   bit                  calm = 1'b0;
   int                  quiet_cycles = 0;

   dual_channel_moving_average_scaler DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_value       (rsp_value),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 21);
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_transfer(req_action, req_channel, req_sample);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_out_channel, rsp_value);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("dual_channel_moving_average_scaler verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic action, input logic channel,
                            input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(99) < 21) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= action;
      req_channel <= channel;
      req_sample  <= sample;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [GAIN_W-1:0] gain,
                                input logic [SUPPLY_W-1:0] supply,
                                input logic [OFFSET_W-1:0] offset,
                                input logic [MUX_W-1:0] mux);
      logic [INDEX_W-1:0] indexes [4];
      logic [CSR_W-1:0]   values [4];
      indexes = '{REG_TURB_GAIN, REG_SUPPLY_MV, REG_ORP_OFFSET, REG_MUX_OFFSET};
      values  = '{CSR_W'(gain), CSR_W'(supply), CSR_W'(offset), CSR_W'(mux)};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= values[i];
         @(posedge clock);
         board.set_register(indexes[i], values[i]);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_item(input int clear_pct);
      int                  pick;
      logic [SAMPLE_W-1:0] sample;
      pick = $urandom_range(99);
      if (pick < 8) sample = '0;
      else if (pick < 16) sample = '1;
      else sample = SAMPLE_W'($urandom_range(0, 1023));
      if ($urandom_range(199) < 2 * clear_pct)
         send_item(ACT_CLEAR, 1'($urandom_range(0, 1)), sample);
      else
         send_item(ACT_SAMPLE, 1'($urandom_range(0, 1)), sample);
   endtask

   initial begin
      int clear_pct;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      send_item(ACT_SAMPLE, CH_TURB, 10'd0);
      send_item(ACT_SAMPLE, CH_ORP, 10'd0);
      send_item(ACT_SAMPLE, CH_TURB, 10'd1023);
      send_item(ACT_SAMPLE, CH_ORP, 10'd1023);
      send_item(ACT_SAMPLE, CH_TURB, 10'd1023);
      send_item(ACT_SAMPLE, CH_ORP, 10'd512);
      send_item(ACT_SAMPLE, CH_TURB, 10'd1);
      send_item(ACT_SAMPLE, CH_ORP, 10'd1);
      send_item(ACT_CLEAR, CH_ORP, 10'd1023);
      send_item(ACT_SAMPLE, CH_TURB, 10'd1023);
      send_item(ACT_SAMPLE, CH_ORP, 10'd0);
      send_item(ACT_CLEAR, CH_TURB, 10'd0);
      send_item(ACT_SAMPLE, CH_ORP, 10'd1023);
      send_item(ACT_SAMPLE, CH_TURB, 10'd0);
      drain();

      // negative averages with extreme gain and offsets
      load_settings(16'hFFFF, 13'd5000, 12'h800, 10'd1023);
      send_item(ACT_SAMPLE, CH_TURB, 10'd1023);
      send_item(ACT_SAMPLE, CH_TURB, 10'd0);
      send_item(ACT_SAMPLE, CH_ORP, 10'd1023);
      send_item(ACT_SAMPLE, CH_ORP, 10'd0);
      send_item(ACT_CLEAR, CH_TURB, 10'd512);
      send_item(ACT_SAMPLE, CH_ORP, 10'd5);
      drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: load_settings(16'hFFFF, 13'd0, 12'h7FF, 10'd0);
            1: load_settings(16'd0, 13'h1FFF, 12'h800, 10'd1023);
            2: load_settings(16'd256, 13'd5000, 12'd0, 10'd1);
            default: load_settings(GAIN_W'($urandom),
                                   SUPPLY_W'($urandom_range(0, 8191)),
                                   OFFSET_W'($urandom),
                                   MUX_W'(($urandom_range(1) == 1)
                                          ? $urandom_range(0, 1023)
                                          : $urandom_range(0, 63)));
         endcase
         calm = (phase == 4);
         clear_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 1 : 5);
         repeat (PHASE_ITEMS) send_random_item(clear_pct);
         drain();
         calm = 1'b0;
      end

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("dual_channel_moving_average_scaler verification clean");
      end else begin
         $display("dual_channel_moving_average_scaler verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dcmas_pkg.sv
rtl/dual_channel_moving_average_scaler.sv
tb/dual_channel_moving_average_scaler_test.sv
